>>> rtl/chrl_pkg.sv
// package for the consistent hash ring lookup block
// types, constants and a hash rotate helper function; no dependencies
package chrl_pkg;

  localparam int RING_TOKENS = 256;
  localparam int IDX_W = $clog2(RING_TOKENS);
  localparam int CNT_W = IDX_W + 1;
  localparam int NODE_W = 16;
  localparam int POS_W = 32;
  localparam int TOK_W = 9;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP = 2'd3;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [31:0] HADD = 32'he6546b64;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIGIT,
    S_TEXT,
    S_BLK_M1,
    S_BLK_M2,
    S_BLK_H,
    S_BLK_H5,
    S_TAIL_M1,
    S_TAIL_M2,
    S_TAIL_H,
    S_FIN_X,
    S_FIN_M1,
    S_FIN_M2,
    S_DIV,
    S_DUP_RD,
    S_DUP_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_BUD_RD,
    S_BUD_CHK,
    S_DONE
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

>>> rtl/consistent_hash_ring_lookup.sv
// consistent hash ring lookup top level: token memory, murmur hash, search; uses chrl_pkg
// clear, the unused code and a lookup on an empty ring go straight to done; a lookup runs the
// hash, the binary search steps and the buddy scan entries; an add runs the duplicate scan over
// the stored tokens, the hash, the divide and then a sorted insert with shift for each token
// one item at a time: busy is high from acceptance until done pulses; results cannot stall
// sync reset clears count, per_node_tokens to 4 and the controller; memory is not cleared
module consistent_hash_ring_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  input  logic [1:0]  operation,
  input  logic [15:0] node_ident,
  input  logic signed [31:0] lookup_key,
  output logic        done,
  output logic        primary_valid,
  output logic [15:0] primary_node,
  output logic [15:0] buddy_node,
  output logic [1:0]  op_status
);

  localparam int IW = chrl_pkg::IDX_W;
  localparam int CW = chrl_pkg::CNT_W;

  // token memory, one entry holds position and owner
  logic [47:0] mem [chrl_pkg::RING_TOKENS];
  logic [47:0] rd_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [47:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  chrl_pkg::state_t state, state_next;
  logic [chrl_pkg::TOK_W-1:0] per_node_tokens;
  logic [CW-1:0] count;
  logic [1:0] op;
  logic [15:0] id;
  logic neg;
  logic [31:0] mag;
  logic [3:0] ndig;
  logic [3:0] digits [10];
  logic [7:0] text [12];
  logic [3:0] tlen;
  logic [1:0] blk;
  logic [31:0] h, k;
  logic [31:0] pos, interval;
  logic [chrl_pkg::TOK_W-1:0] vcnt;
  logic [CW-1:0] i, lo, hi, ins_idx;
  logic [15:0] prim;
  logic [8:0] rem;
  logic [5:0] div_cnt;
  logic [9:0] rem_sh;
  logic [3:0] tlen_now;
  logic add_full;

  logic [31:0] mag_q, mag_r;
  assign mag_q = 32'((64'(mag) * 64'hCCCCCCCD) >> 35);
  assign mag_r = mag - 32'(mag_q * 32'd10);

  logic [CW-1:0] mid, bidx;
  assign mid = lo + ((hi - lo) >> 1);
  assign bidx = (lo + i >= count) ? CW'(lo + i - count) : CW'(lo + i);

  logic [CW:0] room;
  assign room = (CW+1)'(count) + (CW+1)'(per_node_tokens);
  assign add_full = room > (CW+1)'(chrl_pkg::RING_TOKENS);

  assign tlen_now = ndig + ((neg && op == chrl_pkg::OP_LOOKUP) ? 4'd1 : 4'd0);

  // restoring division of 2^32 by per_node_tokens, one quotient bit a cycle
  assign rem_sh = {rem, div_cnt == 6'd0};

  always_comb begin
    state_next = state;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = {pos, id};
    unique case (state)
      chrl_pkg::S_IDLE: if (start) begin
        unique case (operation)
          chrl_pkg::OP_ADD: state_next = chrl_pkg::S_DUP_RD;
          chrl_pkg::OP_LOOKUP: state_next = (count == '0) ? chrl_pkg::S_DONE
                                                          : chrl_pkg::S_DIGIT;
          default: state_next = chrl_pkg::S_DONE;
        endcase
      end
      chrl_pkg::S_DIGIT: if (mag_q == '0 || ndig == 4'd10) state_next = chrl_pkg::S_TEXT;
      chrl_pkg::S_TEXT: state_next = (tlen_now >= 4'd4) ? chrl_pkg::S_BLK_M1
                                   : (tlen_now == 4'd0) ? chrl_pkg::S_FIN_X
                                   : chrl_pkg::S_TAIL_M1;
      chrl_pkg::S_BLK_M1: state_next = chrl_pkg::S_BLK_M2;
      chrl_pkg::S_BLK_M2: state_next = chrl_pkg::S_BLK_H;
      chrl_pkg::S_BLK_H: state_next = chrl_pkg::S_BLK_H5;
      chrl_pkg::S_BLK_H5:
        state_next = (tlen >= 4'd4 * (4'(blk) + 4'd2)) ? chrl_pkg::S_BLK_M1
                   : (tlen[1:0] != 2'd0) ? chrl_pkg::S_TAIL_M1 : chrl_pkg::S_FIN_X;
      chrl_pkg::S_TAIL_M1: state_next = chrl_pkg::S_TAIL_M2;
      chrl_pkg::S_TAIL_M2: state_next = chrl_pkg::S_TAIL_H;
      chrl_pkg::S_TAIL_H: state_next = chrl_pkg::S_FIN_X;
      chrl_pkg::S_FIN_X: state_next = chrl_pkg::S_FIN_M1;
      chrl_pkg::S_FIN_M1: state_next = chrl_pkg::S_FIN_M2;
      chrl_pkg::S_FIN_M2:
        state_next = (op == chrl_pkg::OP_ADD) ? chrl_pkg::S_DIV : chrl_pkg::S_SRCH_RD;
      chrl_pkg::S_DIV: if (div_cnt == 6'd32) state_next = chrl_pkg::S_INS_RD;
      chrl_pkg::S_DUP_RD: begin
        rd_addr = i[IW-1:0];
        state_next = (i < count) ? chrl_pkg::S_DUP_CHK
                   : (add_full || per_node_tokens == '0) ? chrl_pkg::S_DONE
                   : chrl_pkg::S_DIGIT;
      end
      chrl_pkg::S_DUP_CHK: state_next = (rd_data[15:0] == id) ? chrl_pkg::S_DONE
                                                                : chrl_pkg::S_DUP_RD;
      chrl_pkg::S_INS_RD: begin
        rd_addr = i[IW-1:0];
        state_next = (i >= count) ? chrl_pkg::S_SHIFT_RD : chrl_pkg::S_INS_CHK;
      end
      chrl_pkg::S_INS_CHK:
        if (!(rd_data[47:16] < pos || (rd_data[47:16] == pos && rd_data[15:0] <= id)))
          state_next = chrl_pkg::S_SHIFT_RD;
        else state_next = chrl_pkg::S_INS_RD;
      chrl_pkg::S_SHIFT_RD: begin
        rd_addr = IW'(i - 1'b1);
        state_next = (i > ins_idx) ? chrl_pkg::S_SHIFT_WR : chrl_pkg::S_INS_WR;
      end
      chrl_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_addr = i[IW-1:0];
        wr_data = rd_data;
        state_next = chrl_pkg::S_SHIFT_RD;
      end
      chrl_pkg::S_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = ins_idx[IW-1:0];
        state_next = (vcnt == 9'd1) ? chrl_pkg::S_DONE : chrl_pkg::S_INS_RD;
      end
      chrl_pkg::S_SRCH_RD: begin
        rd_addr = mid[IW-1:0];
        state_next = (lo < hi) ? chrl_pkg::S_SRCH_CHK : chrl_pkg::S_BUD_RD;
      end
      chrl_pkg::S_SRCH_CHK: state_next = chrl_pkg::S_SRCH_RD;
      chrl_pkg::S_BUD_RD: begin
        rd_addr = bidx[IW-1:0];
        state_next = chrl_pkg::S_BUD_CHK;
      end
      chrl_pkg::S_BUD_CHK:
        if (i == '0) state_next = chrl_pkg::S_BUD_RD;
        else if (rd_data[15:0] != prim || i + 1'b1 >= count) state_next = chrl_pkg::S_DONE;
        else state_next = chrl_pkg::S_BUD_RD;
      chrl_pkg::S_DONE: state_next = chrl_pkg::S_IDLE;
      default: state_next = chrl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= chrl_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      per_node_tokens <= 9'd4;
      count <= '0;
      done <= 1'b0;
      primary_valid <= 1'b0;
      op_status <= chrl_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      if (cfg_we) per_node_tokens <= cfg_data;
      unique case (state)
        chrl_pkg::S_IDLE: if (start) begin
          op <= operation;
          id <= node_ident;
          neg <= lookup_key[31];
          mag <= (operation == chrl_pkg::OP_ADD) ? 32'(node_ident)
               : (lookup_key[31] ? 32'(-lookup_key) : 32'(lookup_key));
          ndig <= '0;
          i <= '0;
          primary_valid <= 1'b0;
          primary_node <= '0;
          buddy_node <= '0;
          op_status <= chrl_pkg::ST_OK;
          if (operation == chrl_pkg::OP_CLEAR) count <= '0;
          if (operation == chrl_pkg::OP_LOOKUP && count == '0)
            op_status <= chrl_pkg::ST_EMPTY;
        end
        chrl_pkg::S_DIGIT: begin
          digits[ndig] <= mag_r[3:0];
          ndig <= ndig + 4'd1;
          mag <= mag_q;
        end
        chrl_pkg::S_TEXT: begin
          for (int t = 0; t < 12; t++) begin
            if (neg && op == chrl_pkg::OP_LOOKUP)
              text[t] <= (t == 0) ? 8'h2d
                       : (t <= int'(ndig)) ? 8'h30 + 8'(digits[4'(int'(ndig) - t)]) : 8'h0;
            else
              text[t] <= (t < int'(ndig)) ? 8'h30 + 8'(digits[4'(int'(ndig) - 1 - t)])
                       : 8'h0;
          end
          tlen <= tlen_now;
          blk <= '0;
          h <= '0;
        end
        chrl_pkg::S_BLK_M1:
          k <= {text[{blk, 2'd3}], text[{blk, 2'd2}], text[{blk, 2'd1}], text[{blk, 2'd0}]}
               * chrl_pkg::C1;
        chrl_pkg::S_BLK_M2: k <= chrl_pkg::rotl(k, 15) * chrl_pkg::C2;
        chrl_pkg::S_BLK_H: h <= chrl_pkg::rotl(h ^ k, 13);
        chrl_pkg::S_BLK_H5: begin
          h <= h * 32'd5 + chrl_pkg::HADD;
          blk <= blk + 2'd1;
        end
        chrl_pkg::S_TAIL_M1:
          k <= {8'h0,
                (tlen[1:0] == 2'd3) ? text[{blk, 2'd2}] : 8'h0,
                (tlen[1:0] >= 2'd2) ? text[{blk, 2'd1}] : 8'h0,
                text[{blk, 2'd0}]} * chrl_pkg::C1;
        chrl_pkg::S_TAIL_M2: k <= chrl_pkg::rotl(k, 15) * chrl_pkg::C2;
        chrl_pkg::S_TAIL_H: h <= h ^ k;
        chrl_pkg::S_FIN_X: begin
          k <= (h ^ 32'(tlen)) ^ ((h ^ 32'(tlen)) >> 16);
        end
        chrl_pkg::S_FIN_M1: begin
          h <= (k * chrl_pkg::F1) ^ ((k * chrl_pkg::F1) >> 13);
        end
        chrl_pkg::S_FIN_M2: begin
          pos <= (h * chrl_pkg::F2) ^ ((h * chrl_pkg::F2) >> 16);
          i <= '0;
          lo <= '0;
          hi <= count;
          vcnt <= per_node_tokens;
          rem <= '0;
          div_cnt <= '0;
        end
        chrl_pkg::S_DIV: begin
          if (rem_sh >= 10'(per_node_tokens)) begin
            rem <= 9'(rem_sh - 10'(per_node_tokens));
            interval <= {interval[30:0], 1'b1};
          end else begin
            rem <= rem_sh[8:0];
            interval <= {interval[30:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
        end
        chrl_pkg::S_DUP_RD: if (i >= count && add_full) op_status <= chrl_pkg::ST_FULL;
        chrl_pkg::S_DUP_CHK: begin
          if (rd_data[15:0] == id) op_status <= chrl_pkg::ST_DUP;
          i <= i + 1'b1;
        end
        chrl_pkg::S_INS_RD: if (i >= count) ins_idx <= i;
        chrl_pkg::S_INS_CHK:
          if (!(rd_data[47:16] < pos || (rd_data[47:16] == pos && rd_data[15:0] <= id))) begin
            ins_idx <= i;
            i <= count;
          end else i <= i + 1'b1;
        chrl_pkg::S_SHIFT_RD: ;
        chrl_pkg::S_SHIFT_WR: i <= i - 1'b1;
        chrl_pkg::S_INS_WR: begin
          count <= count + 1'b1;
          vcnt <= vcnt - 9'd1;
          pos <= pos + interval;
          i <= '0;
        end
        chrl_pkg::S_SRCH_RD: if (lo >= hi) begin
          if (lo >= count) lo <= '0;
          i <= '0;
        end
        chrl_pkg::S_SRCH_CHK:
          if (rd_data[47:16] < pos) lo <= mid + 1'b1;
          else hi <= mid;
        chrl_pkg::S_BUD_RD: ;
        chrl_pkg::S_BUD_CHK: begin
          if (i == '0) begin
            prim <= rd_data[15:0];
            primary_node <= rd_data[15:0];
            buddy_node <= rd_data[15:0];
            primary_valid <= 1'b1;
            if (count == CW'(1)) i <= count;
            else i <= i + 1'b1;
          end else begin
            if (rd_data[15:0] != prim) buddy_node <= rd_data[15:0];
            i <= i + 1'b1;
          end
        end
        chrl_pkg::S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy = (state != chrl_pkg::S_IDLE);

  done_single_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done);

  done_while_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy);

  count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(chrl_pkg::RING_TOKENS));

  valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    (done && primary_valid) |-> op_status == chrl_pkg::ST_OK);

endmodule
